// ----- hdl/ckgc_pkg.sv -----
// ----------------------------------------------------------------------------
// ckgc_pkg - shared types and constants
// Command codes, the S-box and the column layout for the compression core.
// ----------------------------------------------------------------------------
package ckgc_pkg;

	localparam logic [1:0] CMD_START  = 2'd0;
	localparam logic [1:0] CMD_COLUMN = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	localparam int NUM_COLS = 8;
	localparam int BLK_COLS = 16;

	typedef logic [63:0] col_t;
	typedef col_t [NUM_COLS-1:0] state_t;

	// datapath operation selected by the controller
	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_INIT   = 3'd1; // load initial value, clear count
	localparam logic [2:0] OP_LOAD   = 3'd2; // load P/Q operands from block
	localparam logic [2:0] OP_ROUND  = 3'd3; // one round on P, and on Q when round_q_en is set
	localparam logic [2:0] OP_MIX    = 3'd4; // left ^= right, round zero
	localparam logic [2:0] OP_FOLD   = 3'd5; // chain ^= left ^ right, count++
	localparam logic [2:0] OP_FLOAD  = 3'd6; // left = chain (finish)
	localparam logic [2:0] OP_FFOLD  = 3'd7; // chain ^= left

	typedef struct packed {
		logic [2:0] op;
		logic       round_q_en; // Q register takes a round too
		logic [3:0] rnd;
		logic       wr_col;
		logic [3:0] wr_addr;
		logic       clr_chain;
	} dp_cmd_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [2:0] ROT_Q [8] = '{3'd1,3'd3,3'd5,3'd7,3'd0,3'd2,3'd4,3'd6};

	function automatic logic [7:0] xt(input logic [7:0] a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// one Groestl round; is_q picks the Q constants and shifts
	function automatic state_t grnd(input state_t s, input logic is_q, input logic [3:0] rc);
		logic [7:0] x [8][8];
		logic [7:0] y [8][8];
		logic [7:0] a [8];
		logic [7:0] v;
		logic [2:0] sh;
		state_t o;
		for (int r = 0; r < 8; r++)
			for (int j = 0; j < 8; j++)
				x[r][j] = s[j][8*r +: 8];
		for (int j = 0; j < 8; j++) begin
			if (is_q) begin
				for (int r = 0; r < 7; r++)
					x[r][j] = x[r][j] ^ 8'hff;
				x[7][j] = x[7][j] ^ ({j[3:0], 4'h0} ^ 8'hff ^ {4'h0, rc});
			end else begin
				x[0][j] = x[0][j] ^ ({j[3:0], 4'h0} ^ {4'h0, rc});
			end
		end
		for (int r = 0; r < 8; r++) begin
			sh = is_q ? ROT_Q[r] : r[2:0];
			for (int j = 0; j < 8; j++)
				y[r][j] = SBOX[x[r][3'(j + int'(sh))]];
		end
		for (int j = 0; j < 8; j++)
			for (int k = 0; k < 8; k++) begin
				for (int i = 0; i < 8; i++)
					a[i] = y[(k + i) % 8][j];
				v = xt(a[0]) ^ xt(a[1]) ^ xt(a[2]) ^ a[2] ^ xt(xt(a[3]))
					^ xt(xt(a[4])) ^ a[4] ^ xt(a[5]) ^ a[5]
					^ xt(xt(a[6])) ^ a[6] ^ xt(xt(a[7])) ^ xt(a[7]) ^ a[7];
				o[j][8*k +: 8] = v;
			end
		return o;
	endfunction

endpackage

// ----- hdl/ckgc_datapath.sv -----
// ----------------------------------------------------------------------------
// ckgc_datapath - state registers and round unit
// Block store, chain value, P and Q registers with one round per cycle, Q only when enabled.
// ----------------------------------------------------------------------------
module ckgc_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  ckgc_pkg::dp_cmd_t cmd,
	input  logic [63:0]       column_data,
	input  logic [8:0]        hash_bits,
	input  logic [4:0]        byte_sel,
	output logic [7:0]        digest_byte
);
	ckgc_pkg::col_t   blk_q [ckgc_pkg::BLK_COLS];
	ckgc_pkg::state_t chain_q, left_q, right_q;
	ckgc_pkg::state_t left_rnd, right_rnd;
	logic [63:0]      bidx_q;
	logic [63:0]      cnt;
	logic [63:0]      ctr;
	logic [5:0]       b;

	always_ff @(posedge clk) begin
		if (cmd.wr_col)
			blk_q[cmd.wr_addr] <= column_data;
	end

	assign left_rnd  = ckgc_pkg::grnd(left_q, 1'b0, cmd.rnd);
	assign right_rnd = ckgc_pkg::grnd(right_q, 1'b1, cmd.rnd);
	assign cnt = bidx_q + 64'd1;

	always_comb begin
		for (int r = 0; r < 8; r++)
			ctr[8*r +: 8] = cnt[8*(7-r) +: 8];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// initial value for 256 bits: row 6 of column 7 holds bit 8
			chain_q <= {8'h00, 8'h01, 48'd0, 448'd0};
			left_q  <= '0;
			right_q <= '0;
			bidx_q  <= '0;
		end else begin
			case (cmd.op)
				ckgc_pkg::OP_INIT: begin
					chain_q <= {hash_bits[7:0], 7'd0, hash_bits[8], 48'd0, 448'd0};
					bidx_q  <= '0;
				end
				ckgc_pkg::OP_LOAD: begin
					for (int j = 0; j < 8; j++)
						right_q[j] <= chain_q[j] ^ blk_q[8+j];
					for (int j = 0; j < 7; j++)
						left_q[j] <= blk_q[j];
					left_q[7] <= blk_q[7] ^ ctr;
				end
				ckgc_pkg::OP_ROUND: begin
					left_q <= left_rnd;
					if (cmd.round_q_en)
						right_q <= right_rnd;
				end
				ckgc_pkg::OP_MIX: begin
					left_q <= left_q ^ right_q;
				end
				ckgc_pkg::OP_FOLD: begin
					chain_q <= chain_q ^ left_q ^ right_q;
					bidx_q  <= cnt;
				end
				ckgc_pkg::OP_FLOAD: begin
					left_q <= chain_q;
				end
				ckgc_pkg::OP_FFOLD: begin
					chain_q <= chain_q ^ left_q;
				end
				default: begin
					if (cmd.clr_chain) begin
						chain_q <= '0;
						bidx_q  <= '0;
					end
				end
			endcase
		end
	end

	// byte_sel counts bytes from the end: digest byte k is byte 64-n+k of h
	assign b = 6'd63 - {1'b0, byte_sel};
	assign digest_byte = chain_q[b[5:3]][8*b[2:0] +: 8];
endmodule

// ----- hdl/ckgc_ctrl.sv -----
// ----------------------------------------------------------------------------
// ckgc_ctrl - sequencer
// Handshakes, column count, round count and digest byte count.
// ----------------------------------------------------------------------------
module ckgc_ctrl #(
	parameter int ROUNDS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	output logic              stall,
	input  logic [1:0]        command,
	input  logic [8:0]        hash_bits,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              last_byte,
	output logic [4:0]        byte_sel,
	output ckgc_pkg::dp_cmd_t cmd
);
	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_LOAD  = 4'd1;
	localparam logic [3:0] ST_PQ    = 4'd2;
	localparam logic [3:0] ST_MIX   = 4'd3;
	localparam logic [3:0] ST_P2    = 4'd4;
	localparam logic [3:0] ST_FOLD  = 4'd5;
	localparam logic [3:0] ST_FLOAD = 4'd6;
	localparam logic [3:0] ST_FP    = 4'd7;
	localparam logic [3:0] ST_FFOLD = 4'd8;
	localparam logic [3:0] ST_EMIT  = 4'd9;
	localparam logic [3:0] RLAST = 4'(ROUNDS - 1);

	logic [3:0] state_q;
	logic [3:0] col_q;
	logic [3:0] rnd_q;
	logic [4:0] rem_q;
	logic [5:0] n;
	logic       take;

	assign stall = (state_q != ST_IDLE);
	assign take  = valid && !stall;

	// digest byte count, clamped to 1..32
	always_comb begin
		if (hash_bits[8:3] == 6'd0)      n = 6'd1;
		else if (hash_bits[8:3] > 6'd32) n = 6'd32;
		else                             n = hash_bits[8:3];
	end

	assign out_valid = (state_q == ST_EMIT);
	assign byte_sel  = rem_q;
	assign last_byte = (rem_q == 5'd0);

	always_comb begin
		cmd = '0;
		cmd.rnd = rnd_q;
		cmd.wr_addr = col_q;
		case (state_q)
			ST_IDLE: begin
				if (take && command == ckgc_pkg::CMD_START)
					cmd.op = ckgc_pkg::OP_INIT;
				cmd.wr_col = take && command == ckgc_pkg::CMD_COLUMN;
			end
			ST_LOAD:  cmd.op = ckgc_pkg::OP_LOAD;
			ST_PQ: begin
				cmd.op = ckgc_pkg::OP_ROUND;
				cmd.round_q_en = 1'b1;
			end
			ST_MIX:   cmd.op = ckgc_pkg::OP_MIX;
			ST_P2:    cmd.op = ckgc_pkg::OP_ROUND;
			ST_FOLD:  cmd.op = ckgc_pkg::OP_FOLD;
			ST_FLOAD: cmd.op = ckgc_pkg::OP_FLOAD;
			ST_FP:    cmd.op = ckgc_pkg::OP_ROUND;
			ST_FFOLD: cmd.op = ckgc_pkg::OP_FFOLD;
			ST_EMIT:  cmd.clr_chain = !out_stall && last_byte;
			default:  cmd.op = ckgc_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q   <= '0;
			rnd_q   <= '0;
			rem_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						case (command)
							ckgc_pkg::CMD_START: col_q <= '0;
							ckgc_pkg::CMD_COLUMN: begin
								col_q <= col_q + 4'd1;
								if (col_q == 4'd15)
									state_q <= ST_LOAD;
							end
							ckgc_pkg::CMD_FINISH: state_q <= ST_FLOAD;
							default: ;
						endcase
					end
				end
				ST_LOAD: begin
					rnd_q <= '0;
					state_q <= ST_PQ;
				end
				ST_PQ, ST_P2, ST_FP: begin
					if (rnd_q == RLAST) begin
						rnd_q <= '0;
						state_q <= (state_q == ST_PQ) ? ST_MIX
						         : (state_q == ST_P2) ? ST_FOLD : ST_FFOLD;
					end else begin
						rnd_q <= rnd_q + 4'd1;
					end
				end
				ST_MIX:  state_q <= ST_P2;
				ST_FOLD: state_q <= ST_IDLE;
				ST_FLOAD: begin
					rnd_q <= '0;
					state_q <= ST_FP;
				end
				ST_FFOLD: begin
					rem_q <= 5'(n - 6'd1);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_stall) begin
						rem_q <= rem_q - 5'd1;
						if (last_byte) begin
							col_q <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- hdl/counter_keyed_groestl_compress.sv -----
// ----------------------------------------------------------------------------
// counter_keyed_groestl_compress - counter-keyed Groestl-256 style hash core
// Sequencer plus datapath; P and Q rounds share one cycle per round.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  in        to core    valid / stall       command, column_data
//  out       from core  out_valid/out_stall digest_byte, last_byte
//  cfg       to core    cfg_valid/cfg_ready cfg_data (hash_bits)
//
// A start or a column item is taken without a stall. The sixteenth column
// of a block then holds the input while P and Q run side by side, one round
// per cycle in the round unit, then the second P pass and the fold. Finish
// holds the input for the final P, then one digest byte per cycle while
// out_stall is low. Reset loads the initial value for 256 bits.
// ----------------------------------------------------------------------------
module counter_keyed_groestl_compress #(
	parameter int ROUNDS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic [1:0]  command,
	input  logic [63:0] column_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  digest_byte,
	output logic        last_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data
);
	ckgc_pkg::dp_cmd_t cmd;
	logic [8:0]        hash_bits_q;
	logic [4:0]        byte_sel;

	// config register, always ready
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hash_bits_q <= 9'd256;
		else if (cfg_valid)
			hash_bits_q <= cfg_data;
	end

	ckgc_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall),
		.command(command), .hash_bits(hash_bits_q), .out_valid(out_valid),
		.out_stall(out_stall), .last_byte(last_byte), .byte_sel(byte_sel),
		.cmd(cmd)
	);

	ckgc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .column_data(column_data),
		.hash_bits(hash_bits_q), .byte_sel(byte_sel), .digest_byte(digest_byte)
	);
endmodule

// ----- hdl/ckgc_checker.sv -----
// ----------------------------------------------------------------------------
// ckgc_checker - port-level checks
// Watches the top level's ports only.
// ----------------------------------------------------------------------------
module ckgc_port_checks (
	input logic       clk,
	input logic       arst_n,
	input logic       valid,
	input logic       stall,
	input logic [1:0] command,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] digest_byte,
	input logic       last_byte
);
	// no new item is taken while digest bytes are pending
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stall) else $error("item taken during digest");

	// accepted finish leads to a busy core next cycle
	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid && !stall && command == ckgc_pkg::CMD_FINISH) |=> stall)
		else $error("finish not started");

	// stalled digest byte holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(digest_byte)
		&& $stable(last_byte))) else $error("digest byte changed under stall");

	// after the last byte goes out, the stream ends
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_byte) |=> !out_valid)
		else $error("byte after last");
endmodule

bind counter_keyed_groestl_compress ckgc_port_checks u_chk (
	.clk(clk), .arst_n(arst_n), .valid(valid), .stall(stall), .command(command),
	.out_valid(out_valid), .out_stall(out_stall), .digest_byte(digest_byte),
	.last_byte(last_byte)
);

// ----- sim/ckgc_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ckgc_checker - digest predictor and scoreboard
// Watches the input, output and register channels, computes digest bytes
// and compares each output item with the oldest predicted byte.
// ----------------------------------------------------------------------------
module ckgc_checker #(
	parameter int ROUNDS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	input  logic        stall,
	input  logic [1:0]  command,
	input  logic [63:0] column_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  digest_byte,
	input  logic        last_byte,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [8:0]  cfg_data,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [7:0] dbyte;
		logic       last;
	} digest_item_t;

	digest_item_t     digest_q[$];
	logic [8:0]       digest_len;
	ckgc_pkg::state_t chain;
	ckgc_pkg::col_t   blk[ckgc_pkg::BLK_COLS];
	logic [63:0]      blk_count;
	int               col_cnt;

	function automatic logic [7:0] mul2(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic ckgc_pkg::state_t permute(input ckgc_pkg::state_t s, input bit is_q);
		logic [7:0] x [8][8];
		logic [7:0] t [8];
		logic [7:0] a [8];
		logic [7:0] m2 [8];
		logic [7:0] m4 [8];
		int sh;
		ckgc_pkg::state_t o;
		for (int r = 0; r < 8; r++)
			for (int j = 0; j < 8; j++)
				x[r][j] = s[j][8*r +: 8];
		for (int rnd = 0; rnd < ROUNDS; rnd++) begin
			for (int j = 0; j < 8; j++) begin
				if (is_q) begin
					for (int r = 0; r < 7; r++)
						x[r][j] ^= 8'hff;
					x[7][j] ^= 8'((j << 4) ^ 8'hff ^ rnd);
				end else begin
					x[0][j] ^= 8'((j << 4) ^ rnd);
				end
			end
			for (int r = 0; r < 8; r++) begin
				// Q shifts rows by 1,3,5,7,0,2,4,6
				sh = is_q ? ((2 * r + (r < 4 ? 1 : 0)) % 8) : r;
				for (int j = 0; j < 8; j++)
					t[j] = ckgc_pkg::SBOX[x[r][(j + sh) % 8]];
				for (int j = 0; j < 8; j++)
					x[r][j] = t[j];
			end
			// MixBytes, circulant 02 02 03 04 05 03 05 07
			for (int j = 0; j < 8; j++) begin
				for (int i = 0; i < 8; i++) begin
					a[i]  = x[i][j];
					m2[i] = mul2(a[i]);
					m4[i] = mul2(m2[i]);
				end
				for (int k = 0; k < 8; k++)
					t[k] = m2[k] ^ m2[(k+1)%8] ^ m2[(k+2)%8] ^ a[(k+2)%8]
						^ m4[(k+3)%8] ^ m4[(k+4)%8] ^ a[(k+4)%8]
						^ m2[(k+5)%8] ^ a[(k+5)%8] ^ m4[(k+6)%8] ^ a[(k+6)%8]
						^ m4[(k+7)%8] ^ m2[(k+7)%8] ^ a[(k+7)%8];
				for (int k = 0; k < 8; k++)
					x[k][j] = t[k];
			end
		end
		for (int j = 0; j < 8; j++)
			for (int r = 0; r < 8; r++)
				o[j][8*r +: 8] = x[r][j];
		return o;
	endfunction

	function automatic ckgc_pkg::state_t initial_chain(input logic [8:0] bits);
		ckgc_pkg::state_t s;
		s = '0;
		s[ckgc_pkg::NUM_COLS-1][63:56] = bits[7:0];
		s[ckgc_pkg::NUM_COLS-1][55:48] = {7'd0, bits[8]};
		return s;
	endfunction

	task automatic compress_block();
		ckgc_pkg::state_t pl, pr;
		logic [63:0] cnt;
		cnt = blk_count + 64'd1;
		for (int j = 0; j < ckgc_pkg::NUM_COLS; j++) begin
			pl[j] = blk[j];
			pr[j] = chain[j] ^ blk[ckgc_pkg::NUM_COLS + j];
		end
		// counter goes in big-endian, row 0 most significant
		for (int r = 0; r < 8; r++)
			pl[ckgc_pkg::NUM_COLS-1][8*r +: 8] ^= cnt[8*(7-r) +: 8];
		pl = permute(pl, 1'b0);
		pr = permute(pr, 1'b1);
		pl = permute(pl ^ pr, 1'b0);
		chain = chain ^ pl ^ pr;
		blk_count = cnt;
	endtask

	task automatic finish_hash();
		int n, b;
		digest_item_t it;
		chain = chain ^ permute(chain, 1'b0);
		n = digest_len >> 3;
		if (n < 1) n = 1;
		if (n > 32) n = 32;
		for (int k = 0; k < n; k++) begin
			b = 64 - n + k;
			it.dbyte = chain[b / 8][8*(b % 8) +: 8];
			it.last  = (k + 1 == n);
			digest_q.push_back(it);
		end
		chain = '0;
		blk_count = '0;
		col_cnt = 0;
	endtask

	assign pending = digest_q.size();

	always @(posedge clk or negedge arst_n) begin
		digest_item_t want;
		if (!arst_n) begin
			digest_len = 9'd256;
			chain = initial_chain(9'd256);
			blk_count = '0;
			col_cnt = 0;
			errors = 0;
			digest_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				digest_len = cfg_data;
			if (out_valid && !out_stall) begin
				if (digest_q.size() == 0) begin
					$display("%t: unexpected digest item byte=%h last=%b",
						$realtime, digest_byte, last_byte);
					errors++;
				end else begin
					want = digest_q.pop_front();
					if (digest_byte !== want.dbyte) begin
						$display("%t: digest_byte expected %h actual %h",
							$realtime, want.dbyte, digest_byte);
						errors++;
					end
					if (last_byte !== want.last) begin
						$display("%t: last_byte expected %b actual %b",
							$realtime, want.last, last_byte);
						errors++;
					end
				end
			end
			if (valid && !stall) begin
				case (command)
				ckgc_pkg::CMD_START: begin
					chain = initial_chain(digest_len);
					blk_count = '0;
					col_cnt = 0;
				end
				ckgc_pkg::CMD_COLUMN: begin
					blk[col_cnt] = column_data;
					col_cnt++;
					if (col_cnt == ckgc_pkg::BLK_COLS) begin
						col_cnt = 0;
						compress_block();
					end
				end
				ckgc_pkg::CMD_FINISH: finish_hash();
				default: ;
				endcase
			end
		end
	end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench for counter_keyed_groestl_compress
// Directed hashes over digest lengths and corner commands, then random
// padded-style messages with random idling; the checker scores digests.
// ----------------------------------------------------------------------------
module tb;

	localparam int WATCHDOG = 20000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        valid;
	logic        stall;
	logic [1:0]  command;
	logic [63:0] column_data;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  digest_byte;
	logic        last_byte;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [8:0]  cfg_data;
	int          errors;
	int          pending;
	int          idle_cycles = 0;
	bit          quiet;   // no idling in the closing part of the run
	int          sent;

	counter_keyed_groestl_compress uut (
		.clk(clk), .arst_n(arst_n),
		.valid(valid), .stall(stall), .command(command), .column_data(column_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_byte(digest_byte), .last_byte(last_byte),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	ckgc_checker chk (
		.clk(clk), .arst_n(arst_n),
		.valid(valid), .stall(stall), .command(command), .column_data(column_data),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_byte(digest_byte), .last_byte(last_byte),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog: cycles with no accepted item on any channel
	always @(posedge clk) begin
		if ((valid && !stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver stalls in random bursts, with quiet stretches between
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 8);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// one item; the sender may pause for a burst first
	task automatic send(input logic [1:0] cmd, input logic [63:0] data);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		valid       <= 1'b1;
		command     <= cmd;
		column_data <= data;
		@(posedge clk);
		while (stall) @(posedge clk);
		sent++;
	endtask

	function automatic logic [63:0] rand_col();
		case ($urandom_range(0, 5))
		0: return '0;
		1: return '1;
		default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_block(input int cols);
		for (int i = 0; i < cols; i++)
			send(ckgc_pkg::CMD_COLUMN, rand_col());
	endtask

	// wait for every digest byte plus the compression latency
	task automatic drain();
		valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_len(input logic [8:0] bits);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= bits;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [8:0] lens [6];
		lens = '{9'd256, 9'd8, 9'd0, 9'd511, 9'd160, 9'd13};
		arst_n = 1'b0;
		valid = 1'b0;
		command = ckgc_pkg::CMD_START;
		column_data = '0;
		cfg_valid = 1'b0;
		cfg_data = 9'd256;
		quiet = 1'b0;
		sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset chain, full block, extremes, partial block, unused
		// command, columns after finish without a start
		send(ckgc_pkg::CMD_COLUMN, '1);
		send_block(15);
		send(ckgc_pkg::CMD_FINISH, '0);
		send(ckgc_pkg::CMD_START, '1);
		send(CMD_UNUSED, 64'h0123456789abcdef);
		send_block(5);
		send(ckgc_pkg::CMD_FINISH, '0);
		send_block(16);
		send(ckgc_pkg::CMD_FINISH, '0);
		drain();   // sender holds off until all digests are back

		// digest lengths including out-of-range and non-multiple-of-eight
		foreach (lens[i]) begin
			write_len(lens[i]);
			send(ckgc_pkg::CMD_START, '0);
			send_block(16 * (i % 2));
			send(ckgc_pkg::CMD_FINISH, '0);
		end
		write_len(9'd256);

		// random messages: mostly well-formed, some broken
		while (sent < 400) begin
			if (sent > 340) quiet = 1'b1;
			if ($urandom_range(0, 7) == 0)
				write_len($urandom_range(0, 3) == 0 ? 9'($urandom) : 9'(8 * $urandom_range(1, 32)));
			if ($urandom_range(0, 9) != 0)
				send(ckgc_pkg::CMD_START, rand_col());
			send_block(16 * $urandom_range(0, 2) + ($urandom_range(0, 4) == 0 ? $urandom_range(1, 15) : 0));
			if ($urandom_range(0, 9) == 0)
				send(CMD_UNUSED, rand_col());
			send(ckgc_pkg::CMD_FINISH, rand_col());
		end
		drain();
		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
